FILE: rtl/deq_pkg.sv
// Shared types, constants and ring index helper for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    // Ring geometry.
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Operation codes.
    localparam logic [1:0] OP_QUERY     = 2'd0;
    localparam logic [1:0] OP_PUSH_BACK = 2'd1;
    localparam logic [1:0] OP_POP_FRONT = 2'd2;
    localparam logic [1:0] OP_POP_BACK  = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    // Depth as a count value and as a wide position sum.
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);
    localparam logic [CNT_W:0]   SUM_DEPTH = (CNT_W + 1)'(DEPTH);

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [DATA_W-1:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [4:0]               entry_total;
        logic                     is_empty;
        logic [1:0]               error_code;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec_op;
        logic load_result;
    } deq_cmd_t;

    // Folds a position sum below twice the depth back into the ring.
    function automatic logic [IDX_W-1:0] ring_wrap(input logic [CNT_W:0] sum);
        logic [CNT_W:0] adj;
        adj = (sum >= SUM_DEPTH) ? (sum - SUM_DEPTH) : sum;
        return adj[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/double_ended_queue.sv
// Top level of the double-ended queue: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// A queue of signed 32-bit words kept in a ring of DEPTH entries (16) with a
// front index and an entry count. Each input item carries one operation:
// query, push at the back, pop from the front or pop from the back. Every
// item yields exactly one result item giving the front and back words, the
// count, an empty flag and an error code; a push into a full ring is dropped
// and flagged, and a pop on an empty queue is flagged. The block works on one
// item at a time: an accepted item passes through the EXEC, READ and LOAD
// states before its result is valid, and the next item is taken the cycle
// after that result is taken. This sequence is set by the ring memory, which
// is written in EXEC and whose registered reads of both ends are loaded into
// the result in LOAD.
module double_ended_queue
    import deq_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_item
);

    deq_cmd_t cmd;

    deq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    deq_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_item  (s_item),
        .m_item  (m_item)
    );

endmodule

`default_nettype wire

FILE: rtl/deq_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]                      rd_data_a,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]                      rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // One write and two reads each cycle; read data is registered.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_a <= mem_reg[rd_addr_a];
        rd_data_b <= mem_reg[rd_addr_b];
    end

endmodule

`default_nettype wire

FILE: rtl/deq_ctrl.sv
// Controller state machine that sequences one queue operation at a time.
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output deq_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Handshake outputs follow the state directly.
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    // Commands to the datapath.
    always_comb begin
        cmd.load_item   = (state_reg == ST_IDLE) && s_valid;
        cmd.exec_op     = (state_reg == ST_EXEC);
        cmd.load_result = (state_reg == ST_LOAD);
    end

    // Next state: take an item, update the ring, read both ends, present the result.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/deq_datapath.sv
// Datapath holding the ring memory, the front index, the count and the result register.
`timescale 1ns / 1ps
`default_nettype none

module deq_datapath
    import deq_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire deq_cmd_t cmd,
    input  wire in_item_t s_item,
    output out_item_t     m_item
);

    in_item_t         item_reg;
    logic [IDX_W-1:0] front_reg;
    logic [IDX_W-1:0] front_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       err_reg;
    logic [1:0]       err_next;
    out_item_t        result_reg;
    out_item_t        result_next;

    logic             is_full;
    logic             is_none;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [CNT_W-1:0] back_offset;
    logic [IDX_W-1:0] back_addr;
    logic [DATA_W-1:0] front_data;
    logic [DATA_W-1:0] back_data;

    assign is_full = (count_reg == CNT_DEPTH);
    assign is_none = (count_reg == '0);

    // Ring positions: the free slot after the back, and the back entry itself.
    assign wr_addr     = ring_wrap({1'b0, CNT_W'(front_reg)} + {1'b0, count_reg});
    assign back_offset = is_none ? '0 : (count_reg - CNT_W'(1));
    assign back_addr   = ring_wrap({1'b0, CNT_W'(front_reg)} + {1'b0, back_offset});

    // Operation decode with the full and empty checks.
    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        err_next   = ERR_NONE;
        wr_en      = 1'b0;
        case (item_reg.opcode)
            OP_QUERY: begin
                err_next = ERR_NONE;
            end
            OP_PUSH_BACK: begin
                if (is_full) begin
                    err_next = ERR_FULL;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (is_none) begin
                    err_next = ERR_EMPTY;
                end else begin
                    front_next = ring_wrap({1'b0, CNT_W'(front_reg)} + (CNT_W + 1)'(1));
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (is_none) begin
                    err_next = ERR_EMPTY;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
                err_next = ERR_NONE;
            end
        endcase
    end

    // Ring storage, read at the front and the back every cycle.
    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk      (aclk),
        .wr_en     (wr_en && cmd.exec_op),
        .wr_addr   (wr_addr),
        .wr_data   (item_reg.push_value),
        .rd_addr_a (front_reg),
        .rd_data_a (front_data),
        .rd_addr_b (back_addr),
        .rd_data_b (back_data)
    );

    // Result assembly; an empty queue reports zero at both ends.
    always_comb begin
        result_next.entry_total = 5'(count_reg);
        result_next.is_empty    = is_none;
        result_next.error_code  = err_reg;
        if (is_none) begin
            result_next.front_value = '0;
            result_next.back_value  = '0;
        end else begin
            result_next.front_value = front_data;
            result_next.back_value  = back_data;
        end
    end

    // Ring pointers and error code.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
            err_reg   <= ERR_NONE;
        end else if (cmd.exec_op) begin
            front_reg <= front_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    // Item and result holding registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_item;
        end
        if (cmd.load_result) begin
            result_reg <= result_next;
        end
    end

    assign m_item = result_reg;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the double-ended queue with a built-in predictor.
`timescale 1ns / 1ps

module testbench;
    import deq_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    // Predicted view of the queue for every item accepted and not yet answered.
    out_item_t queue_views_due[$];
    int        mismatch_total;

    // Predictor state: the ring, the position of the oldest word and the fill.
    logic signed [DATA_W-1:0] shadow_ring [DEPTH];
    int unsigned              shadow_head;
    int unsigned              shadow_fill;

    // Idle controls shared between the test tasks and the result-side process.
    bit src_idle_on;
    bit sink_idle_on;
    int hold_off_cycles;

    double_ended_queue dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Free-running clock with a 2 ns period.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Applies one operation to the shadow queue and returns the view it leaves.
    function automatic out_item_t apply_deque_op(input in_item_t op_item);
        out_item_t view;
        view = '0;
        view.error_code = ERR_NONE;
        case (op_item.opcode)
            OP_PUSH_BACK: begin
                if (shadow_fill >= DEPTH) begin
                    view.error_code = ERR_FULL;
                end else begin
                    shadow_ring[(shadow_head + shadow_fill) % DEPTH] = op_item.push_value;
                    shadow_fill++;
                end
            end
            OP_POP_FRONT: begin
                if (shadow_fill == 0) begin
                    view.error_code = ERR_EMPTY;
                end else begin
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_fill--;
                end
            end
            OP_POP_BACK: begin
                if (shadow_fill == 0) begin
                    view.error_code = ERR_EMPTY;
                end else begin
                    shadow_fill--;
                end
            end
            default: begin
            end
        endcase
        if (shadow_fill != 0) begin
            view.front_value = shadow_ring[shadow_head];
            view.back_value  = shadow_ring[(shadow_head + shadow_fill - 1) % DEPTH];
        end
        view.entry_total = shadow_fill[4:0];
        view.is_empty    = (shadow_fill == 0);
        return view;
    endfunction

    // Offers one item after an optional gap and predicts its result on acceptance.
    // Valid is left high afterwards so that a following item can go back to back.
    task automatic send_op(input logic [1:0] opcode, input logic signed [DATA_W-1:0] value);
        in_item_t op_item;
        int       gap;
        op_item.opcode     = opcode;
        op_item.push_value = value;
        gap = src_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= op_item;
        do @(posedge aclk); while (!s_ready);
        queue_views_due.push_back(apply_deque_op(op_item));
    endtask

    // Stops offering items and waits until every predicted result has been taken.
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (queue_views_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Random word with the two extremes drawn more often than chance would.
    function automatic logic signed [DATA_W-1:0] pick_word();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            return 32'sh7FFF_FFFF;
        end else if (pick == 1) begin
            return 32'sh8000_0000;
        end
        return $urandom;
    endfunction

    // Query and both pops on an empty queue, each with a non-zero value present.
    task automatic test_empty_queue();
        send_op(OP_QUERY, 32'sh7FFF_FFFF);
        send_op(OP_POP_FRONT, 32'sh8000_0000);
        send_op(OP_POP_BACK, -32'sd1);
        wait_for_idle();
    endtask

    // Fills the ring with the extremes first, then pushes once more while full.
    task automatic test_fill_to_full();
        send_op(OP_PUSH_BACK, 32'sh7FFF_FFFF);
        send_op(OP_PUSH_BACK, 32'sh8000_0000);
        send_op(OP_PUSH_BACK, 32'sd0);
        send_op(OP_PUSH_BACK, -32'sd1);
        for (int i = 4; i < DEPTH; i++) begin
            send_op(OP_PUSH_BACK, pick_word());
        end
        send_op(OP_PUSH_BACK, pick_word());
        send_op(OP_QUERY, pick_word());
        wait_for_idle();
    endtask

    // Moves the front on so that the next push wraps round the end of the ring.
    task automatic test_wrap_and_both_ends();
        send_op(OP_POP_FRONT, pick_word());
        send_op(OP_PUSH_BACK, pick_word());
        send_op(OP_POP_BACK, pick_word());
        send_op(OP_POP_FRONT, pick_word());
        wait_for_idle();
    endtask

    // Random operations in alternating filling and draining stretches, so that the
    // queue swings between full and empty and its ends wrap many times.
    task automatic test_mixed_traffic(input int count, input bit src_gaps, input bit sink_gaps);
        bit         filling;
        int         stretch;
        int         roll;
        logic [1:0] opcode;
        src_idle_on  = src_gaps;
        sink_idle_on = sink_gaps;
        filling = 1'b1;
        stretch = $urandom_range(10, 40);
        for (int i = 0; i < count; i++) begin
            if (stretch == 0) begin
                filling = !filling;
                stretch = $urandom_range(10, 40);
            end
            stretch--;
            roll = $urandom_range(0, 99);
            if (filling) begin
                opcode = (roll < 60) ? OP_PUSH_BACK : (roll < 75) ? OP_POP_FRONT :
                         (roll < 90) ? OP_POP_BACK : OP_QUERY;
            end else begin
                opcode = (roll < 20) ? OP_PUSH_BACK : (roll < 55) ? OP_POP_FRONT :
                         (roll < 90) ? OP_POP_BACK : OP_QUERY;
            end
            send_op(opcode, pick_word());
        end
        wait_for_idle();
    endtask

    // The receiver holds off for a long stretch while items keep coming back to
    // back, so the block has to stall its input until results drain again.
    task automatic test_output_backpressure();
        src_idle_on     = 1'b0;
        sink_idle_on    = 1'b0;
        hold_off_cycles = 200;
        for (int i = 0; i < 24; i++) begin
            send_op((i % 3 == 2) ? OP_POP_FRONT : OP_PUSH_BACK, pick_word());
        end
        wait_for_idle();
    endtask

    // Result side: random stalls per item, or one long hold-off when requested.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge aclk);
                hold_off_cycles = 0;
            end else if (sink_idle_on) begin
                stall = $urandom_range(0, 7);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid && hold_off_cycles == 0);
        end
    end

    // Compares every taken result with the oldest prediction, field by field.
    always @(posedge aclk) begin : check_view
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (queue_views_due.size() == 0) begin
                mismatch_total++;
                if (mismatch_total <= 10) begin
                    $display("%0t: result with no item outstanding: %p", $realtime, m_item);
                end
            end else begin
                want = queue_views_due.pop_front();
                if (m_item.front_value !== want.front_value
                        || m_item.back_value !== want.back_value
                        || m_item.entry_total !== want.entry_total
                        || m_item.is_empty !== want.is_empty
                        || m_item.error_code !== want.error_code) begin
                    mismatch_total++;
                    if (mismatch_total <= 10) begin
                        $display("%0t: mismatch, expected %p, got %p", $realtime, want, m_item);
                    end
                end
            end
        end
    end

    // Safety net against a hung handshake.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Test sequence.
    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_item          = '0;
        mismatch_total  = 0;
        hold_off_cycles = 0;
        src_idle_on     = 1'b1;
        sink_idle_on    = 1'b1;
        shadow_head     = 0;
        shadow_fill     = 0;
        for (int i = 0; i < DEPTH; i++) begin
            shadow_ring[i] = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_queue();
        test_fill_to_full();
        test_wrap_and_both_ends();
        test_mixed_traffic(300, 1'b1, 1'b1);
        test_mixed_traffic(200, 1'b0, 1'b0);
        test_output_backpressure();
        test_mixed_traffic(200, 1'b1, 1'b0);
        test_mixed_traffic(200, 1'b0, 1'b1);

        if (mismatch_total == 0 && queue_views_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/deq_datapath.sv
rtl/double_ended_queue.sv
sim/testbench.sv
